### sv/pwm_clock_divider_search_top_assert.svh
// Assertion macros for the PWM clock divider search block.
// Used by the top level only; needs clk and rst_n in scope.
`ifndef PWM_CLOCK_DIVIDER_SEARCH_TOP_ASSERT_SVH
`define PWM_CLOCK_DIVIDER_SEARCH_TOP_ASSERT_SVH

// same-cycle implication
`define PCDS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PCDS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/pcds_pkg.sv
// Package for the PWM clock divider search: constants, widths, FSM state type,
// and the structs passed between the sequencer and the quotient unit. No dependencies.
package pcds_pkg;

  localparam int BASE_FREQ        = 160000000;
  localparam int MAX_BUFFER_BYTES = 1024;
  localparam int MAX_DIVIDER      = 63;
  localparam int FRAC_BITS        = 16;

  localparam int RATE_W = 28;
  localparam int DIV_W  = 6;
  localparam int LEN_W  = 11;
  localparam int LVL_W  = 14;

  // achieved rate in Q16 is floor(ACH_NUM / (d1*d2))
  localparam longint unsigned ACH_NUM =
    (longint'(BASE_FREQ) << FRAC_BITS) / (8 * MAX_BUFFER_BYTES);
  localparam int ACH_W = $clog2(ACH_NUM + 1);
  localparam int CMP_W = RATE_W + FRAC_BITS;

  localparam int PB_W  = 2 * DIV_W;
  localparam int DEN_W = PB_W + RATE_W + 3;
  localparam int NUM_W = $clog2(BASE_FREQ + 1);
  localparam int CNT_W = $clog2(NUM_W);

  typedef enum logic [2:0] {
    S_IDLE,
    S_INIT,
    S_SCAN,
    S_DRAIN,
    S_PROD,
    S_DEN,
    S_DIV,
    S_DONE
  } pcds_state_t;

  typedef struct packed {
    logic             vld;
    logic [DIV_W-1:0] d1;
    logic [DIV_W-1:0] d2;
  } pcds_pair_t;

  typedef struct packed {
    logic             vld;
    logic [DIV_W-1:0] d1;
    logic [DIV_W-1:0] d2;
    logic [ACH_W-1:0] ach;
  } pcds_res_t;

endpackage

### sv/pcds_if.sv
// Valid/ready channel interfaces for the PWM clock divider search.
// Depends on pcds_pkg for field widths.
interface pcds_in_if import pcds_pkg::*;;
  logic              valid;
  logic              ready;
  logic [RATE_W-1:0] rate_hz;

  modport source (output valid, output rate_hz, input ready);
  modport sink   (input valid, input rate_hz, output ready);
endinterface

interface pcds_out_if import pcds_pkg::*;;
  logic             valid;
  logic             ready;
  logic [DIV_W-1:0] first_divider;
  logic [DIV_W-1:0] second_divider;
  logic [LEN_W-1:0] buffer_length;
  logic [LVL_W-1:0] level_count;

  modport source (output valid, output first_divider, output second_divider,
                  output buffer_length, output level_count, input ready);
  modport sink   (input valid, input first_divider, input second_divider,
                  input buffer_length, input level_count, output ready);
endinterface

### sv/pcds_quot.sv
// Pipelined achieved-rate unit: floor(ACH_NUM/(d1*d2)), one pair per cycle.
// Depends on pcds_pkg. Uses a quotient table for d1 and a reciprocal multiply for d2.
module pcds_quot import pcds_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  pcds_pair_t iss,
  output pcds_res_t  res,
  output logic       busy
);

  localparam int TBL_N = 2 ** DIV_W;
  localparam int QD_W  = ACH_W + DIV_W;

  logic [ACH_W-1:0] kdiv_tbl  [TBL_N];
  logic [ACH_W-1:0] recip_tbl [TBL_N];

  for (genvar G = 0; G < TBL_N; G++) begin : g_tbl
    if (G < 2) begin : g_unused
      assign kdiv_tbl[G]  = '0;
      assign recip_tbl[G] = '0;
    end else begin : g_entry
      localparam longint unsigned KD = ACH_NUM / G;
      localparam longint unsigned RC = (longint'(1) << ACH_W) / G;
      assign kdiv_tbl[G]  = ACH_W'(KD);
      assign recip_tbl[G] = ACH_W'(RC);
    end
  end

  logic               v1_r, v2_r, v3_r;
  logic [DIV_W-1:0]   d1_1_r, d2_1_r, d1_2_r, d2_2_r, d1_3_r, d2_3_r;
  logic [ACH_W-1:0]   x1_r, m1_r, x2_r, q3_r;
  logic [2*ACH_W-1:0] prod2_r;

  logic [ACH_W-1:0] q0;
  logic [QD_W-1:0]  qd;
  logic [QD_W-1:0]  rr;
  logic             fix;
  logic [ACH_W-1:0] q_nxt;

  always_comb begin
    q0    = prod2_r[2*ACH_W-1 -: ACH_W];
    qd    = QD_W'(q0) * QD_W'(d2_2_r);
    rr    = QD_W'(x2_r) - qd;
    fix   = rr >= QD_W'(d2_2_r);
    q_nxt = q0 + ACH_W'(fix);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= iss.vld;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    d1_1_r  <= iss.d1;
    d2_1_r  <= iss.d2;
    x1_r    <= kdiv_tbl[iss.d1];
    m1_r    <= recip_tbl[iss.d2];
    d1_2_r  <= d1_1_r;
    d2_2_r  <= d2_1_r;
    x2_r    <= x1_r;
    prod2_r <= (2*ACH_W)'(x1_r) * (2*ACH_W)'(m1_r);
    d1_3_r  <= d1_2_r;
    d2_3_r  <= d2_2_r;
    q3_r    <= q_nxt;
  end

  assign res.vld = v3_r;
  assign res.d1  = d1_3_r;
  assign res.d2  = d2_3_r;
  assign res.ach = q3_r;
  assign busy    = v1_r | v2_r | v3_r;

endmodule

### sv/pwm_clock_divider_search_top.sv
// Top level of the PWM clock divider search: sequencer, best-pair tracking,
// buffer length divider and output register. Depends on pcds_pkg, pcds_if, pcds_quot.
// From accept to result valid, either the (2,2) pair is kept or the full scan runs (1953
// pairs, one per cycle through the 3-stage achieved-rate unit); both paths end with
// a 28-step restoring division for the buffer length.
// Throughput: one item at a time, next accept possible in the cycle after the result loads. Reset: rst_n.
module pwm_clock_divider_search_top import pcds_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  pcds_in_if.sink      in_ch,
  pcds_out_if.source   out_ch
);

  `include "pwm_clock_divider_search_top_assert.svh"

  localparam logic [DIV_W-1:0] DMIN = DIV_W'(2);
  localparam logic [DIV_W-1:0] DMAX = DIV_W'(MAX_DIVIDER);

  pcds_state_t state_r, state_nxt;

  pcds_pair_t iss;
  pcds_res_t  res;
  logic       q_busy;

  logic [RATE_W-1:0] rate_r;
  logic [DIV_W-1:0]  d1_r, d2_r, b1_r, b2_r;
  logic [ACH_W-1:0]  ab_r;
  logic [PB_W-1:0]   pb_r;
  logic [DEN_W-1:0]  den_r, rem_r;
  logic [NUM_W-1:0]  num_r, quo_r;
  logic [CNT_W-1:0]  cnt_r;

  logic             out_valid_r;
  logic [DIV_W-1:0] out_d1_r, out_d2_r;
  logic [LEN_W-1:0] out_len_r;
  logic [LVL_W-1:0] out_lvl_r;

  logic             in_rdy, accept, load_out;
  logic [CMP_W-1:0] req_q16, ach_ext, ab_ext;
  logic             init_neg, replace, scan_last;
  logic [DEN_W:0]   rem_sh, rem_diff;
  logic             rem_ge;
  logic [LEN_W-1:0] len_val;
  logic [LVL_W-1:0] lvl_val;

  pcds_quot u_quot (
    .clk   (clk),
    .rst_n (rst_n),
    .iss   (iss),
    .res   (res),
    .busy  (q_busy)
  );

  always_comb begin
    req_q16   = {rate_r, FRAC_BITS'(0)};
    ach_ext   = CMP_W'(res.ach);
    ab_ext    = CMP_W'(ab_r);
    init_neg  = ach_ext > req_q16;
    replace   = ((ab_ext > req_q16) && (ach_ext < ab_ext)) ||
                ((ach_ext < req_q16) && (ach_ext > ab_ext));
    scan_last = (d1_r == DMAX) && (d2_r == DMAX);
    rem_sh    = {rem_r, num_r[NUM_W-1]};
    rem_diff  = rem_sh - {1'b0, den_r};
    rem_ge    = rem_sh >= {1'b0, den_r};
    if (quo_r == '0) begin
      len_val = LEN_W'(1);
    end else if (quo_r > NUM_W'(MAX_BUFFER_BYTES)) begin
      len_val = LEN_W'(MAX_BUFFER_BYTES);
    end else begin
      len_val = LEN_W'(quo_r);
    end
    lvl_val = LVL_W'({len_val, 3'b000}) + LVL_W'(1);
  end

  // outputs of the sequencer
  always_comb begin
    in_rdy   = 1'b0;
    load_out = 1'b0;
    iss.vld  = 1'b0;
    iss.d1   = d1_r;
    iss.d2   = d2_r;
    unique case (state_r)
      S_IDLE: begin
        in_rdy  = 1'b1;
        iss.vld = in_ch.valid;
        iss.d1  = DMIN;
        iss.d2  = DMIN;
      end
      S_SCAN: begin
        iss.vld = 1'b1;
      end
      S_DONE: begin
        load_out = !out_valid_r || out_ch.ready;
      end
      default: begin
      end
    endcase
  end

  assign accept = in_rdy && in_ch.valid;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_ch.valid) state_nxt = S_INIT;
      S_INIT:  if (res.vld) state_nxt = init_neg ? S_SCAN : S_PROD;
      S_SCAN:  if (scan_last) state_nxt = S_DRAIN;
      S_DRAIN: if (!q_busy) state_nxt = S_PROD;
      S_PROD:  state_nxt = S_DEN;
      S_DEN:   state_nxt = S_DIV;
      S_DIV:   if (cnt_r == '0) state_nxt = S_DONE;
      S_DONE:  if (load_out) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rate_r <= in_ch.rate_hz;
      d1_r   <= DMIN;
      d2_r   <= DMIN;
    end
    if (state_r == S_SCAN) begin
      if (d2_r == DMAX) begin
        d1_r <= d1_r + DIV_W'(1);
        d2_r <= d1_r + DIV_W'(1);
      end else begin
        d2_r <= d2_r + DIV_W'(1);
      end
    end
    if (res.vld && ((state_r == S_INIT) || replace)) begin
      ab_r <= res.ach;
      b1_r <= res.d1;
      b2_r <= res.d2;
    end
    if (state_r == S_PROD) begin
      pb_r <= PB_W'(b1_r) * PB_W'(b2_r);
    end
    if (state_r == S_DEN) begin
      den_r <= {(PB_W+RATE_W)'(pb_r) * (PB_W+RATE_W)'(rate_r), 3'b000};
      rem_r <= '0;
      num_r <= NUM_W'(BASE_FREQ);
      cnt_r <= CNT_W'(NUM_W - 1);
    end
    if (state_r == S_DIV) begin
      rem_r <= rem_ge ? DEN_W'(rem_diff) : DEN_W'(rem_sh);
      num_r <= {num_r[NUM_W-2:0], 1'b0};
      quo_r <= {quo_r[NUM_W-2:0], rem_ge};
      cnt_r <= cnt_r - CNT_W'(1);
    end
    if (load_out) begin
      out_d1_r  <= b1_r;
      out_d2_r  <= b2_r;
      out_len_r <= len_val;
      out_lvl_r <= lvl_val;
    end
  end

  assign in_ch.ready           = in_rdy;
  assign out_ch.valid          = out_valid_r;
  assign out_ch.first_divider  = out_d1_r;
  assign out_ch.second_divider = out_d2_r;
  assign out_ch.buffer_length  = out_len_r;
  assign out_ch.level_count    = out_lvl_r;

  `PCDS_ASSERT_IMP(a_res_in_search, res.vld, (state_r == S_INIT) || (state_r == S_SCAN) || (state_r == S_DRAIN), "achieved rate outside search phase")
  `PCDS_ASSERT_NXT(a_accept_init, in_ch.valid && in_ch.ready, state_r == S_INIT, "accepted item did not start search")
  `PCDS_ASSERT_IMP(a_prod_drained, state_r == S_PROD, !q_busy, "length step with rate pipeline busy")
  `PCDS_ASSERT_NXT(a_load_valid, load_out, out_valid_r && (state_r == S_IDLE), "result load lost")

endmodule
